### hdl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg: shared constants for the parametric line clipper
// Default widths, window register codes and edge count.
// ----------------------------------------------------------------------------
`default_nettype none

package lcr_pkg;

	// default parameter values
	localparam int COORD_BITS_DEF = 14;
	localparam int FRAC_BITS_DEF  = 16;

	// window register width and reset values
	localparam int WIN_W = 12;
	localparam logic [WIN_W-1:0] WIN_MIN_RST = '0;
	localparam logic [WIN_W-1:0] WIN_MAX_RST = '1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 2'd3;

	// four parametric edge tests: left, right, bottom, top
	localparam int NUM_EDGES = 4;

endpackage

`default_nettype wire

### hdl/lcr_div_cell.sv
// ----------------------------------------------------------------------------
// lcr_div_cell: a restoring division step, applied to every edge in parallel
// Produces one fraction bit of each edge ratio and hands the partial
// remainders, quotients and side data on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_div_cell #(
	parameter int MW = 16,
	parameter int QW = 17,
	parameter int SW = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_vld,
	output logic                      in_rdy,
	input  wire logic [MW-1:0]        rem_i  [lcr_pkg::NUM_EDGES],
	input  wire logic [MW-1:0]        den_i  [lcr_pkg::NUM_EDGES],
	input  wire logic [QW-1:0]        quot_i [lcr_pkg::NUM_EDGES],
	input  wire logic [SW-1:0]        side_i,
	output logic                      out_vld,
	input  wire logic                 out_rdy,
	output logic [MW-1:0]             rem_o  [lcr_pkg::NUM_EDGES],
	output logic [MW-1:0]             den_o  [lcr_pkg::NUM_EDGES],
	output logic [QW-1:0]             quot_o [lcr_pkg::NUM_EDGES],
	output logic [SW-1:0]             side_o
);
	import lcr_pkg::*;

	logic [MW:0]   r2     [NUM_EDGES];
	logic [MW-1:0] rem_n  [NUM_EDGES];
	logic [QW-1:0] quot_n [NUM_EDGES];
	logic          vld_q;

	// trial subtract of the doubled remainder
	always_comb begin
		for (int e = 0; e < NUM_EDGES; e++) begin
			r2[e] = {rem_i[e], 1'b0};
			if (r2[e] >= {1'b0, den_i[e]}) begin
				rem_n[e]  = MW'(r2[e] - {1'b0, den_i[e]});
				quot_n[e] = {quot_i[e][QW-2:0], 1'b1};
			end else begin
				rem_n[e]  = MW'(r2[e]);
				quot_n[e] = {quot_i[e][QW-2:0], 1'b0};
			end
		end
	end

	assign in_rdy  = !vld_q || out_rdy;
	assign out_vld = vld_q;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_rdy) begin
			vld_q <= in_vld;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			rem_o  <= rem_n;
			den_o  <= den_i;
			quot_o <= quot_n;
			side_o <= side_i;
		end
	end

endmodule

`default_nettype wire

### hdl/line_clip_rect_parametric.sv
// ----------------------------------------------------------------------------
// line_clip_rect_parametric: parametric clipping of a segment to a window
// Runs the left/right/bottom/top edge tests through a chain of division
// cells, narrows entry and exit parameters, interpolates, saturates endpoints.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, start/end x,y         | in
//  output  | out_valid, out_stall, visible, clip_*     | out
//  config  | cfg_we, cfg_idx, cfg_wdata                | in
//
// One segment per cycle while out_stall is low; a segment passes through the
// setup stage, the division cells (one fraction bit each) and the resolve,
// multiply and output stages. Reset clears all stage valids and loads the
// default window. Each stage holds while the next one is full and stalled;
// a stall of the output backs up stage by stage to in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module line_clip_rect_parametric #(
	parameter int COORD_BITS      = lcr_pkg::COORD_BITS_DEF,
	parameter int PARAM_FRAC_BITS = lcr_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lcr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [lcr_pkg::WIN_W-1:0]      cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [COORD_BITS-1:0]   start_x,
	input  wire logic signed [COORD_BITS-1:0]   start_y,
	input  wire logic signed [COORD_BITS-1:0]   end_x,
	input  wire logic signed [COORD_BITS-1:0]   end_y,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                visible,
	output logic [lcr_pkg::WIN_W-1:0]           clip_start_x,
	output logic [lcr_pkg::WIN_W-1:0]           clip_start_y,
	output logic [lcr_pkg::WIN_W-1:0]           clip_end_x,
	output logic [lcr_pkg::WIN_W-1:0]           clip_end_y
);
	import lcr_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int F  = PARAM_FRAC_BITS;
	localparam int AW = ((C > WIN_W + 1) ? C : WIN_W + 1) + 1;
	localparam int QW = F + 1;
	localparam int RW = F + 2;
	localparam int DW = C + 1;
	localparam int MP = F + C + 3;
	localparam int PV = F + C + 5;
	localparam int FW = 5;
	localparam int SW = 2 * C + 2 * DW + NUM_EDGES * FW;
	localparam logic [QW-1:0] ONE = QW'(1) << F;
	localparam logic signed [PV-1:0] HALF = PV'(1) << (F - 1);

	// window registers
	logic [WIN_W-1:0] x_min_q, y_min_q, x_max_q, y_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= WIN_MIN_RST;
			y_min_q <= WIN_MIN_RST;
			x_max_q <= WIN_MAX_RST;
			y_max_q <= WIN_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_X_MIN: x_min_q <= cfg_wdata;
				REG_Y_MIN: y_min_q <= cfg_wdata;
				REG_X_MAX: x_max_q <= cfg_wdata;
				REG_Y_MAX: y_max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------- setup stage ----------------
	logic signed [DW-1:0] dx_c, dy_c;
	logic signed [AW-1:0] p_c [NUM_EDGES];
	logic signed [AW-1:0] q_c [NUM_EDGES];
	logic [AW-1:0]        pm_c [NUM_EDGES];
	logic [AW-1:0]        qm_c [NUM_EDGES];
	logic [AW-1:0]        rem_c [NUM_EDGES];
	logic [QW-1:0]        quot_c [NUM_EDGES];
	logic [FW-1:0]        flg_c [NUM_EDGES];
	logic [SW-1:0]        side_c;
	logic                 ibit_c, ovf_c;

	always_comb begin
		dx_c = DW'(end_x) - DW'(start_x);
		dy_c = DW'(end_y) - DW'(start_y);
		p_c[0] = -AW'(dx_c);
		q_c[0] = AW'(start_x) - $signed(AW'(x_min_q));
		p_c[1] = AW'(dx_c);
		q_c[1] = $signed(AW'(x_max_q)) - AW'(start_x);
		p_c[2] = -AW'(dy_c);
		q_c[2] = AW'(start_y) - $signed(AW'(y_min_q));
		p_c[3] = AW'(dy_c);
		q_c[3] = $signed(AW'(y_max_q)) - AW'(start_y);
		side_c = {start_x, start_y, dx_c, dy_c, {(NUM_EDGES * FW){1'b0}}};
		for (int e = 0; e < NUM_EDGES; e++) begin
			pm_c[e] = p_c[e][AW-1] ? AW'(-p_c[e]) : AW'(p_c[e]);
			qm_c[e] = q_c[e][AW-1] ? AW'(-q_c[e]) : AW'(q_c[e]);
			ovf_c   = {1'b0, qm_c[e]} >= {pm_c[e], 1'b0};
			ibit_c  = qm_c[e] >= pm_c[e];
			rem_c[e]  = ibit_c ? AW'(qm_c[e] - pm_c[e]) : qm_c[e];
			quot_c[e] = QW'(ibit_c);
			// flags: p zero, q negative, p negative, ratio negative, overflow
			flg_c[e] = {(p_c[e] == '0), q_c[e][AW-1], p_c[e][AW-1],
				q_c[e][AW-1] ^ p_c[e][AW-1], ovf_c};
			side_c[e*FW +: FW] = flg_c[e];
		end
	end

	logic                 v0_q, r0;
	logic [AW-1:0]        rem_s0  [NUM_EDGES];
	logic [AW-1:0]        den_s0  [NUM_EDGES];
	logic [QW-1:0]        quot_s0 [NUM_EDGES];
	logic [SW-1:0]        side_s0;

	// division cell chain wires
	logic          cv   [F+1];
	logic          cr   [F+1];
	logic [AW-1:0] crem [F+1][NUM_EDGES];
	logic [AW-1:0] cden [F+1][NUM_EDGES];
	logic [QW-1:0] cquo [F+1][NUM_EDGES];
	logic [SW-1:0] csid [F+1];

	assign r0       = !v0_q || cr[0];
	assign in_stall = !r0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
		end else if (r0) begin
			v0_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (r0 && in_valid) begin
			rem_s0  <= rem_c;
			den_s0  <= pm_c;
			quot_s0 <= quot_c;
			side_s0 <= side_c;
		end
	end

	assign cv[0]   = v0_q;
	assign crem[0] = rem_s0;
	assign cden[0] = den_s0;
	assign cquo[0] = quot_s0;
	assign csid[0] = side_s0;

	// one cell per fraction bit
	for (genvar k = 0; k < F; k++) begin : g_cell
		lcr_div_cell #(
			.MW(AW),
			.QW(QW),
			.SW(SW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.in_vld (cv[k]),
			.in_rdy (cr[k]),
			.rem_i  (crem[k]),
			.den_i  (cden[k]),
			.quot_i (cquo[k]),
			.side_i (csid[k]),
			.out_vld(cv[k+1]),
			.out_rdy(cr[k+1]),
			.rem_o  (crem[k+1]),
			.den_o  (cden[k+1]),
			.quot_o (cquo[k+1]),
			.side_o (csid[k+1])
		);
	end

	// ---------------- resolve stage ----------------
	logic [FW-1:0]        fl   [NUM_EDGES];
	logic signed [RW-1:0] rat  [NUM_EDGES];
	logic signed [RW-1:0] u1_c, u2_c;
	logic                 rej_c;

	always_comb begin
		u1_c  = '0;
		u2_c  = RW'(ONE);
		rej_c = 1'b0;
		for (int e = 0; e < NUM_EDGES; e++) begin
			fl[e] = csid[F][e*FW +: FW];
			if (fl[e][0] || cquo[F][e] > ONE) begin
				rat[e] = RW'(ONE) + RW'(1);
			end else begin
				rat[e] = RW'(cquo[F][e]);
			end
			if (fl[e][1] && (fl[e][0] || cquo[F][e] != '0)) begin
				rat[e] = -RW'(1);
			end
			if (fl[e][4]) begin
				if (fl[e][3]) begin
					rej_c = 1'b1;
				end
			end else if (fl[e][2]) begin
				if (rat[e] > u1_c) begin
					u1_c = rat[e];
				end
			end else begin
				if (rat[e] < u2_c) begin
					u2_c = rat[e];
				end
			end
		end
		if (u1_c > u2_c) begin
			rej_c = 1'b1;
		end
	end

	logic                 vr_q, rr, rm;
	logic [QW-1:0]        u1_s1, u2_s1;
	logic                 rej_s1;
	logic signed [C-1:0]  x1_s1, y1_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;

	assign cr[F] = rr;
	assign rr    = !vr_q || rm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vr_q <= 1'b0;
		end else if (rr) begin
			vr_q <= cv[F];
		end
	end

	always_ff @(posedge clk) begin
		if (rr && cv[F]) begin
			u1_s1  <= QW'(u1_c);
			u2_s1  <= QW'(u2_c);
			rej_s1 <= rej_c;
			{x1_s1, y1_s1, dx_s1, dy_s1} <= csid[F][SW-1 -: 2*C + 2*DW];
		end
	end

	// ---------------- multiply stage ----------------
	logic                 vm_q, ro;
	logic signed [MP-1:0] psx_s2, psy_s2, pex_s2, pey_s2;
	logic signed [C-1:0]  x1_s2, y1_s2;
	logic                 rej_s2;

	assign rm = !vm_q || ro;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vm_q <= 1'b0;
		end else if (rm) begin
			vm_q <= vr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rm && vr_q) begin
			psx_s2 <= MP'($signed({1'b0, u1_s1}) * dx_s1);
			psy_s2 <= MP'($signed({1'b0, u1_s1}) * dy_s1);
			pex_s2 <= MP'($signed({1'b0, u2_s1}) * dx_s1);
			pey_s2 <= MP'($signed({1'b0, u2_s1}) * dy_s1);
			x1_s2  <= x1_s1;
			y1_s2  <= y1_s1;
			rej_s2 <= rej_s1;
		end
	end

	// ---------------- round and saturate ----------------
	function automatic logic [WIN_W-1:0] fin(
		input logic signed [C-1:0]  base,
		input logic signed [MP-1:0] prod,
		input logic [WIN_W-1:0]     lo,
		input logic [WIN_W-1:0]     hi
	);
		logic signed [PV-1:0] v, rnd, lo_s, hi_s;
		v    = (PV'(base) <<< F) + PV'(prod);
		lo_s = $signed(PV'(lo));
		hi_s = $signed(PV'(hi));
		if (!v[PV-1]) begin
			rnd = (v + HALF) >>> F;
		end else begin
			rnd = -(((-v) + HALF) >>> F);
		end
		if (rnd < lo_s) begin
			rnd = lo_s;
		end
		if (rnd > hi_s) begin
			rnd = hi_s;
		end
		return rnd[WIN_W-1:0];
	endfunction

	logic vo_q;

	assign ro        = !vo_q || !out_stall;
	assign out_valid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (ro) begin
			vo_q <= vm_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ro && vm_q) begin
			if (rej_s2) begin
				visible      <= 1'b0;
				clip_start_x <= '0;
				clip_start_y <= '0;
				clip_end_x   <= '0;
				clip_end_y   <= '0;
			end else begin
				visible      <= 1'b1;
				clip_start_x <= fin(x1_s2, psx_s2, x_min_q, x_max_q);
				clip_start_y <= fin(y1_s2, psy_s2, y_min_q, y_max_q);
				clip_end_x   <= fin(x1_s2, pex_s2, x_min_q, x_max_q);
				clip_end_y   <= fin(y1_s2, pey_s2, y_min_q, y_max_q);
			end
		end
	end

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for line_clip_rect_parametric
// A driver sends segments from a queue of pending segments. A predictor
// computes the clipped result for each accepted transaction, and a monitor
// checks every output transaction against the oldest prediction. The run
// moves through several clip windows, from the reset window to inverted
// ones. Both sides idle at random, and once the receiver holds off long
// enough that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import lcr_pkg::*;

	localparam int CB        = COORD_BITS_DEF;
	localparam int FB        = FRAC_BITS_DEF;
	localparam longint ONE   = longint'(1) << FB;
	localparam longint HALF  = longint'(1) << (FB - 1);
	localparam int LATENCY   = FB + 4;
	localparam int LIMIT     = 600000;
	localparam int CMIN      = -(1 << (CB - 1));
	localparam int CMAX      = (1 << (CB - 1)) - 1;

	typedef struct packed {
		logic signed [CB-1:0] sx, sy, ex, ey;
	} segment_t;

	typedef struct packed {
		logic             vis;
		logic [WIN_W-1:0] csx, csy, cex, cey;
	} clipped_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_X_MIN;
	logic [WIN_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic visible;
	logic [WIN_W-1:0] clip_start_x, clip_start_y, clip_end_x, clip_end_y;

	// window copy used by the predictor
	logic [WIN_W-1:0] win_lo_x = WIN_MIN_RST, win_lo_y = WIN_MIN_RST;
	logic [WIN_W-1:0] win_hi_x = WIN_MAX_RST, win_hi_y = WIN_MAX_RST;

	segment_t pending_segs[$];
	clipped_t expected_clips[$];
	bit seg_taken = 1'b0;
	bit idle_enable = 1'b1;
	int send_gap = 0;
	int recv_gap = 0;
	int long_hold_left = 0;
	int errors = 0;
	int cycles = 0;
	int n_sent = 0;
	int n_visible = 0;
	int n_rejected = 0;
	int n_windows = 0;

	line_clip_rect_parametric i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_stall(out_stall), .visible(visible),
		.clip_start_x(clip_start_x), .clip_start_y(clip_start_y),
		.clip_end_x(clip_end_x), .clip_end_y(clip_end_y)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// base + u*d rounded to nearest, ties away from zero
	function automatic longint lerp_round(longint base, longint u, longint d);
		longint v;
		v = base * ONE + u * d;
		if (v >= 0) return (v + HALF) / ONE;
		return -((-v + HALF) / ONE);
	endfunction

	// raise to the low edge first, then lower to the high edge
	function automatic logic [WIN_W-1:0] clamp_win(longint v, longint lo, longint hi);
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v[WIN_W-1:0];
	endfunction

	// clip one segment against the current window
	function automatic clipped_t clip_segment(segment_t s);
		longint x1, y1, x2, y2, dx, dy, u1, u2, r;
		longint xl, yl, xh, yh;
		longint p[4], q[4];
		longint sx, sy, ex, ey;
		clipped_t c;
		x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
		xl = win_lo_x; yl = win_lo_y; xh = win_hi_x; yh = win_hi_y;
		dx = x2 - x1; dy = y2 - y1;
		u1 = 0; u2 = ONE;
		c = '0;
		p[0] = -dx; q[0] = x1 - xl;
		p[1] = dx;  q[1] = xh - x1;
		p[2] = -dy; q[2] = y1 - yl;
		p[3] = dy;  q[3] = yh - y1;
		for (int k = 0; k < NUM_EDGES; k++) begin
			if (p[k] == 0) begin
				if (q[k] < 0) return c;
			end else begin
				r = (q[k] * ONE) / p[k];
				if (p[k] < 0) begin
					if (r > u2) return c;
					if (r > u1) u1 = r;
				end else begin
					if (r < u1) return c;
					if (r < u2) u2 = r;
				end
			end
		end
		sx = x1; sy = y1; ex = x2; ey = y2;
		if (u2 < ONE) begin
			ex = lerp_round(x1, u2, dx);
			ey = lerp_round(y1, u2, dy);
		end
		if (u1 > 0) begin
			sx = lerp_round(x1, u1, dx);
			sy = lerp_round(y1, u1, dy);
		end
		c.vis = 1'b1;
		c.csx = clamp_win(sx, xl, xh);
		c.csy = clamp_win(sy, yl, yh);
		c.cex = clamp_win(ex, xl, xh);
		c.cey = clamp_win(ey, yl, yh);
		return c;
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (!idle_enable) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// accepted input transaction: record its prediction
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_clips.push_back(clip_segment({start_x, start_y, end_x, end_y}));
			seg_taken = 1'b1;
			n_sent++;
		end
	end

	// driver
	always @(negedge clk) begin
		if (!in_valid || seg_taken) begin
			seg_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_segs.size() > 0) begin
				segment_t s;
				s = pending_segs.pop_front();
				start_x <= s.sx; start_y <= s.sy; end_x <= s.ex; end_y <= s.ey;
				in_valid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with an occasional long hold-off
	always @(negedge clk) begin
		if (long_hold_left > 0) begin
			long_hold_left--;
			out_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			recv_gap = pick_gap();
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			clipped_t e, a;
			a = {visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y};
			if (expected_clips.size() == 0) begin
				$display("%0t: unexpected transaction %h", $time, a);
				errors++;
			end else begin
				e = expected_clips.pop_front();
				if (a.vis) n_visible++; else n_rejected++;
				if (a.vis !== e.vis) begin
					$display("%0t: visible exp %0d got %0d", $time, e.vis, a.vis);
					errors++;
				end
				if (a.csx !== e.csx) begin
					$display("%0t: clip_start_x exp %0d got %0d", $time, e.csx, a.csx);
					errors++;
				end
				if (a.csy !== e.csy) begin
					$display("%0t: clip_start_y exp %0d got %0d", $time, e.csy, a.csy);
					errors++;
				end
				if (a.cex !== e.cex) begin
					$display("%0t: clip_end_x exp %0d got %0d", $time, e.cex, a.cex);
					errors++;
				end
				if (a.cey !== e.cey) begin
					$display("%0t: clip_end_y exp %0d got %0d", $time, e.cey, a.cey);
					errors++;
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_clips.size());
			$display("tb failed");
			$finish;
		end
	end

	function automatic logic signed [CB-1:0] rnd_coord(int lo, int hi);
		int v;
		v = int'($urandom_range(0, hi - lo)) + lo;
		return v[CB-1:0];
	endfunction

	// random segment, biased toward the window
	task automatic add_random_seg();
		segment_t s;
		logic [63:0] rbits;
		int m, lo, hi;
		m = $urandom_range(0, 9);
		lo = int'(win_lo_x < win_hi_x ? win_lo_x : win_hi_x) - 300;
		hi = int'(win_lo_x > win_hi_x ? win_lo_x : win_hi_x) + 300;
		s.sx = rnd_coord(lo, hi); s.ex = rnd_coord(lo, hi);
		lo = int'(win_lo_y < win_hi_y ? win_lo_y : win_hi_y) - 300;
		hi = int'(win_lo_y > win_hi_y ? win_lo_y : win_hi_y) + 300;
		s.sy = rnd_coord(lo, hi); s.ey = rnd_coord(lo, hi);
		rbits = {$urandom(), $urandom()};
		case (m)
			0, 1: s = rbits[4*CB-1:0];
			2: s.ex = s.sx;
			3: s.ey = s.sy;
			4: begin s.ex = s.sx; s.ey = s.sy; end
			default: ;
		endcase
		pending_segs.push_back(s);
	endtask

	task automatic add_seg(int x1, int y1, int x2, int y2);
		pending_segs.push_back({x1[CB-1:0], y1[CB-1:0], x2[CB-1:0], y2[CB-1:0]});
	endtask

	task automatic drain();
		while (pending_segs.size() > 0 || in_valid || expected_clips.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_window(int xl, int yl, int xh, int yh);
		logic [WIN_W-1:0] v[4];
		v[0] = xl[WIN_W-1:0]; v[1] = yl[WIN_W-1:0];
		v[2] = xh[WIN_W-1:0]; v[3] = yh[WIN_W-1:0];
		for (int k = 0; k < 4; k++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_idx <= k[CFG_IDX_W-1:0];
			cfg_wdata <= v[k];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		win_lo_x = v[REG_X_MIN]; win_lo_y = v[REG_Y_MIN];
		win_hi_x = v[REG_X_MAX]; win_hi_y = v[REG_Y_MAX];
		n_windows++;
	endtask

	task automatic random_phase(int n);
		repeat (n) add_random_seg();
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset window
		add_seg(CMIN, CMIN, CMAX, CMAX);
		add_seg(CMAX, CMAX, CMIN, CMIN);
		add_seg(100, 200, 300, 400);
		add_seg(-1, 0, -1, 4095);
		add_seg(0, 0, 0, 4095);
		add_seg(4095, 4095, 4095, 4095);
		add_seg(4096, 10, 4096, 10);
		add_seg(-500, 2000, 5000, 2000);
		add_seg(2000, -5000, 2000, 6000);
		add_seg(-10, 10, 10, -10);
		add_seg(-100, 4095, 0, 4195);
		add_seg(CMIN, CMAX, CMAX, CMIN);
		add_seg(-1, -1, 1, 1);
		add_seg(4094, 3, 4097, 7);
		drain();

		// directed: small window
		write_window(100, 200, 300, 400);
		add_seg(0, 0, 400, 600);
		add_seg(300, 400, 500, 700);
		add_seg(50, 250, 350, 250);
		add_seg(50, 100, 50, 500);
		add_seg(100, 500, 200, 400);
		add_seg(200, 300, 200, 300);
		add_seg(0, 300, 1, 301);
		add_seg(101, 201, 299, 399);
		random_phase(150);

		// inverted window
		write_window(3000, 3000, 1000, 1000);
		random_phase(120);

		// single point window
		write_window(2048, 2048, 2048, 2048);
		add_seg(0, 0, 4096, 4096);
		add_seg(2048, 0, 2048, 4095);
		random_phase(100);

		// full window with a long receiver hold-off
		write_window(0, 0, 4095, 4095);
		repeat (300) add_random_seg();
		@(posedge clk);
		long_hold_left = 250;
		drain();

		// no idling at all
		idle_enable = 1'b0;
		write_window(0, 4095, 4095, 0);
		random_phase(150);
		idle_enable = 1'b1;

		// random windows
		repeat (7) begin
			write_window($urandom_range(0, 2047), $urandom_range(0, 2047),
				$urandom_range(2048, 4095), $urandom_range(2048, 4095));
			random_phase(100);
		end
		write_window(4095, 4095, 4095, 4095);
		random_phase(60);

		repeat (LATENCY * 2) @(posedge clk);
		$display("sent %0d segments over %0d windows plus reset window", n_sent, n_windows);
		$display("results: %0d visible, %0d rejected", n_visible, n_rejected);
		if (errors == 0 && expected_clips.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_clips.size());
			$display("tb failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
hdl/lcr_pkg.sv
hdl/lcr_div_cell.sv
hdl/line_clip_rect_parametric.sv
dv/tb.sv
